### design/rlf_pkg.sv
// rlf_pkg: shared types, codes and reset values of the RGB LED fade controller.
// No dependencies; used by every module in design/.
package rlf_pkg;

    localparam int IDX_W = 6;

    // switch event codes
    localparam logic [1:0] EV_ON      = 2'd0;
    localparam logic [1:0] EV_STANDBY = 2'd1;

    // command codes
    localparam logic [2:0] MODE_ON      = 3'd1;
    localparam logic [2:0] MODE_STANDBY = 3'd2;
    localparam logic [2:0] MODE_SCALE   = 3'd3;
    localparam logic [2:0] MODE_COLOUR  = 3'd4;

    // register indexes
    localparam logic [1:0] REG_FADE_STEP      = 2'd0;
    localparam logic [1:0] REG_ON_COLOUR      = 2'd1;
    localparam logic [1:0] REG_STANDBY_FIRST  = 2'd2;
    localparam logic [1:0] REG_STANDBY_SECOND = 2'd3;

    // register reset values
    localparam logic [7:0]  FADE_STEP_RST      = 8'd5;
    localparam logic [23:0] ON_COLOUR_RST      = 24'h966400;
    localparam logic [23:0] STANDBY_FIRST_RST  = 24'h001E1E;
    localparam logic [23:0] STANDBY_SECOND_RST = 24'h001414;

    // one LED's wanted and shown pattern
    typedef struct packed {
        logic [23:0] tcol;
        logic        tlit;
        logic [23:0] scol;
        logic        slit;
    } t_led;

    // configuration registers
    typedef struct packed {
        logic [7:0]  fade_step;
        logic [23:0] on_colour;
        logic [23:0] standby_first;
        logic [23:0] standby_second;
    } t_cfg;

    // the tick item being worked on
    typedef struct packed {
        logic [1:0]  switch_event;
        logic [2:0]  mode;
        logic [8:0]  brightness;
        logic [23:0] colour;
    } t_cmd;

    // control from the sequencer to the head unit
    typedef struct packed {
        logic upd;     // update pass: apply event and command
        logic differ;  // fade pass: patterns differed after update
    } t_head_ctl;

endpackage

### design/rlf_cell.sv
// rlf_cell: one stage of the LED ring, holds the pattern of one LED.
// Depends on rlf_pkg (t_led).
module rlf_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  rlf_pkg::t_led i_next,
    output rlf_pkg::t_led o_led
);

    rlf_pkg::t_led r_led;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led <= '0;
        end else if (i_shift) begin
            r_led <= i_next;
        end
    end

    assign o_led = r_led;

endmodule

### design/rlf_head.sv
// rlf_head: processing unit at the head of the LED ring; applies event and
// command to the wanted pattern, or fades the shown one. Depends on rlf_pkg.
module rlf_head (
    input  rlf_pkg::t_led             i_led,
    input  logic [rlf_pkg::IDX_W-1:0] i_idx,
    input  rlf_pkg::t_head_ctl        i_ctl,
    input  rlf_pkg::t_cmd             i_cmd,
    input  rlf_pkg::t_cfg             i_cfg,
    output rlf_pkg::t_led             o_led,
    output logic                      o_mismatch
);

    function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [8:0] k);
        logic [16:0] p;
        begin
            p = 17'(c) * 17'(k);
            scale_chan = p[16] ? 8'hFF : p[15:8];
        end
    endfunction

    function automatic logic [7:0] move_chan(input logic [7:0] cur, input logic [7:0] tgt,
                                             input logic wanted, input logic [7:0] fs);
        logic [7:0] d;
        begin
            d = (tgt > cur) ? (tgt - cur) : (cur - tgt);
            if (!wanted) begin
                move_chan = (cur < fs) ? 8'd0 : (cur - fs);
            end else if (d < fs) begin
                move_chan = tgt;
            end else begin
                move_chan = (tgt > cur) ? (cur + fs) : (cur - fs);
            end
        end
    endfunction

    logic [23:0] w_sb_col;
    logic        w_sb_lit;
    logic [23:0] w_ev_col;
    logic        w_ev_lit;
    logic [23:0] w_new_col;
    logic        w_new_lit;
    logic [7:0]  w_r;
    logic [7:0]  w_g;
    logic [7:0]  w_b;
    logic [7:0]  w_fs;

    assign w_fs = i_cfg.fade_step;

    // standby pattern for this LED
    always_comb begin
        w_sb_col = 24'd0;
        w_sb_lit = 1'b0;
        if (i_idx == rlf_pkg::IDX_W'(0)) begin
            w_sb_col = i_cfg.standby_first;
            w_sb_lit = 1'b1;
        end else if (i_idx == rlf_pkg::IDX_W'(1)) begin
            w_sb_col = i_cfg.standby_second;
            w_sb_lit = 1'b1;
        end
    end

    // event first
    always_comb begin
        case (i_cmd.switch_event)
            rlf_pkg::EV_ON: begin
                w_ev_col = i_cfg.on_colour;
                w_ev_lit = 1'b1;
            end
            rlf_pkg::EV_STANDBY: begin
                w_ev_col = w_sb_col;
                w_ev_lit = w_sb_lit;
            end
            default: begin
                w_ev_col = i_led.tcol;
                w_ev_lit = i_led.tlit;
            end
        endcase
    end

    // then the command
    always_comb begin
        w_new_lit = w_ev_lit;
        case (i_cmd.mode)
            rlf_pkg::MODE_ON: begin
                w_new_col = i_cfg.on_colour;
                w_new_lit = 1'b1;
            end
            rlf_pkg::MODE_STANDBY: begin
                w_new_col = w_sb_col;
                w_new_lit = w_sb_lit;
            end
            rlf_pkg::MODE_SCALE: begin
                w_new_col = {scale_chan(w_ev_col[23:16], i_cmd.brightness),
                             scale_chan(w_ev_col[15:8],  i_cmd.brightness),
                             scale_chan(w_ev_col[7:0],   i_cmd.brightness)};
            end
            rlf_pkg::MODE_COLOUR: begin
                w_new_col = i_cmd.colour;
            end
            default: begin
                w_new_col = w_ev_col;
            end
        endcase
    end

    assign w_r = move_chan(i_led.scol[23:16], i_led.tcol[23:16], i_led.tlit, w_fs);
    assign w_g = move_chan(i_led.scol[15:8],  i_led.tcol[15:8],  i_led.tlit, w_fs);
    assign w_b = move_chan(i_led.scol[7:0],   i_led.tcol[7:0],   i_led.tlit, w_fs);

    always_comb begin
        o_led = i_led;
        if (i_ctl.upd) begin
            o_led.tcol = w_new_col;
            o_led.tlit = w_new_lit;
        end else if (i_ctl.differ) begin
            o_led.scol = {w_r, w_g, w_b};
            o_led.slit = !((w_r < w_fs) && (w_g < w_fs) && (w_b < w_fs));
        end
    end

    assign o_mismatch = (w_new_col != i_led.scol) || (w_new_lit != i_led.slit);

endmodule

### design/rgb_led_fade_controller_top.sv
// rgb_led_fade_controller_top: RGB LED fade controller, ring of LED cells.
// Depends on rlf_pkg, rlf_cell and rlf_head.
//
// Each input item is one tick. The LED patterns live in a ring of LED_COUNT
// cells that rotates through one shared head unit. After an item is taken the
// ring makes two full turns: the first applies the switch event and command to
// every wanted pattern and notes whether any LED still differs from its shown
// pattern; the second fades each shown pattern if so and hands one result item
// per LED, index order, to the output register. No new item is taken until
// both turns of the ring are done, and the second turn pauses while the
// output stalls. Configuration goes over the APB-style port at byte
// addresses 0, 4, 8, 12.
module rgb_led_fade_controller_top #(
    parameter int LED_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // tick items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_switch_event,
    input  logic [2:0]  i_mode,
    input  logic [8:0]  i_brightness,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    // LED result items
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_led_index,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic        o_lit,
    output logic        o_last_led
);

    localparam int CW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [CW-1:0] LAST = CW'(LED_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_UPD  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_differ, n_differ;
    rlf_pkg::t_cfg     r_cfg;
    rlf_pkg::t_cmd     r_cmd;
    logic              r_out_valid;
    logic [5:0]        r_out_idx;
    logic [23:0]       r_out_col;
    logic              r_out_lit;
    logic              r_out_last;

    rlf_pkg::t_led      w_led [LED_COUNT];
    rlf_pkg::t_led      w_head_out;
    rlf_pkg::t_head_ctl w_ctl;
    logic               w_mismatch;
    logic               w_shift;
    logic               w_slot_free;
    logic               w_in_acc;
    logic               w_cfg_wr;

    // ---------------------------------------------------------------- config
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fade_step      <= rlf_pkg::FADE_STEP_RST;
            r_cfg.on_colour      <= rlf_pkg::ON_COLOUR_RST;
            r_cfg.standby_first  <= rlf_pkg::STANDBY_FIRST_RST;
            r_cfg.standby_second <= rlf_pkg::STANDBY_SECOND_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                rlf_pkg::REG_FADE_STEP:      r_cfg.fade_step      <= pwdata[7:0];
                rlf_pkg::REG_ON_COLOUR:      r_cfg.on_colour      <= pwdata[23:0];
                rlf_pkg::REG_STANDBY_FIRST:  r_cfg.standby_first  <= pwdata[23:0];
                rlf_pkg::REG_STANDBY_SECOND: r_cfg.standby_second <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            rlf_pkg::REG_FADE_STEP:      prdata = {24'd0, r_cfg.fade_step};
            rlf_pkg::REG_ON_COLOUR:      prdata = {8'd0, r_cfg.on_colour};
            rlf_pkg::REG_STANDBY_FIRST:  prdata = {8'd0, r_cfg.standby_first};
            rlf_pkg::REG_STANDBY_SECOND: prdata = {8'd0, r_cfg.standby_second};
            default:                     prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------- sequencer
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    // update turn never stalls; fade turn moves only into a free output slot
    always_comb begin
        case (r_state)
            S_UPD:   w_shift = 1'b1;
            S_EMIT:  w_shift = w_slot_free;
            default: w_shift = 1'b0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_differ = r_differ;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state  = S_UPD;
                    n_cnt    = '0;
                    n_differ = 1'b0;
                end
            end
            S_UPD: begin
                n_differ = r_differ || w_mismatch;
                if (r_cnt == LAST) begin
                    n_state = S_EMIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_EMIT: begin
                if (w_shift) begin
                    if (r_cnt == LAST) begin
                        n_state = S_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_differ <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_differ <= n_differ;
        end
    end

    // hold the tick item for both turns
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd.switch_event <= i_switch_event;
            r_cmd.mode         <= i_mode;
            r_cmd.brightness   <= i_brightness;
            r_cmd.colour       <= {i_red_in, i_green_in, i_blue_in};
        end
    end

    // ------------------------------------------------------------------ ring
    assign w_ctl.upd    = (r_state == S_UPD);
    assign w_ctl.differ = r_differ;

    rlf_head u_head (
        .i_led      (w_led[0]),
        .i_idx      (rlf_pkg::IDX_W'(r_cnt)),
        .i_ctl      (w_ctl),
        .i_cmd      (r_cmd),
        .i_cfg      (r_cfg),
        .o_led      (w_head_out),
        .o_mismatch (w_mismatch)
    );

    // cell 0 feeds the head; the head's result re-enters at the tail
    for (genvar g = 0; g < LED_COUNT; g++) begin : g_cell
        rlf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_next  ((g == LED_COUNT - 1) ? w_head_out : w_led[(g + 1) % LED_COUNT]),
            .o_led   (w_led[g])
        );
    end

    // --------------------------------------------------------- output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && w_shift) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_shift) begin
            r_out_idx  <= 6'(r_cnt);
            r_out_col  <= w_head_out.scol;
            r_out_lit  <= w_head_out.slit;
            r_out_last <= (r_cnt == LAST);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led_index = r_out_idx;
    assign o_red_out   = r_out_col[23:16];
    assign o_green_out = r_out_col[15:8];
    assign o_blue_out  = r_out_col[7:0];
    assign o_lit       = r_out_lit;
    assign o_last_led  = r_out_last;

    // ------------------------------------------------------------ assertions
    a_acc_starts_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_UPD) && (r_cnt == '0))
        else $error("accepted item did not start the update turn");

    a_update_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) && (r_cnt == LAST) |=> (r_state == S_EMIT) && (r_cnt == '0))
        else $error("update turn did not hand over to the fade turn");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_led |-> (o_led_index == 6'(LED_COUNT - 1)))
        else $error("last LED flag on wrong index");

    a_no_emit_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_EMIT) && !(o_out_valid && !i_out_ready) |=> !o_out_valid)
        else $error("result item outside the fade turn");

endmodule

### test/tb.sv
// tb: self-checking bench for rgb_led_fade_controller_top, one tick item in, LED_COUNT results out.
// Depends on rlf_pkg and the design files; keeps its own copy of the wanted and shown patterns.
module tb;

    localparam int LED_COUNT = 16;
    localparam int QUIET_MAX = 3000;     // cycles with no handshake before giving up
    localparam int STALL_LEN = 300;      // long output hold-off, fills the block
    localparam int PHASE_TICKS = 75;

    // codes the package leaves implicit
    localparam logic [1:0] EV_NONE   = 2'd2;
    localparam logic [1:0] EV_MAX    = 2'd3;   // unknown event, acts as none
    localparam logic [2:0] MODE_NONE = 3'd0;
    localparam logic [2:0] MODE_MAX  = 3'd7;   // unknown commands run up to here

    typedef struct packed {
        logic [1:0] switch_event;
        logic [2:0] mode;
        logic [8:0] brightness;
        logic [7:0] red, green, blue;
    } t_tick;

    typedef struct packed {
        logic [5:0] led_index;
        logic [7:0] red, green, blue;
        logic       lit, last_led;
    } t_led_res;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // configuration port
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // tick items in
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] switch_event = '0;
    logic [2:0] mode = '0;
    logic [8:0] brightness = '0;
    logic [7:0] red_in = '0, green_in = '0, blue_in = '0;

    // LED items out
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [5:0] led_index;
    logic [7:0] red_out, green_out, blue_out;
    logic       lit, last_led;

    rgb_led_fade_controller_top #(
        .LED_COUNT(LED_COUNT)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_switch_event (switch_event),
        .i_mode         (mode),
        .i_brightness   (brightness),
        .i_red_in       (red_in),
        .i_green_in     (green_in),
        .i_blue_in      (blue_in),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_led_index    (led_index),
        .o_red_out      (red_out),
        .o_green_out    (green_out),
        .o_blue_out     (blue_out),
        .o_lit          (lit),
        .o_last_led     (last_led)
    );

    // Predicted state: register copy plus wanted and shown pattern per LED.
    rlf_pkg::t_cfg cfg = {rlf_pkg::FADE_STEP_RST, rlf_pkg::ON_COLOUR_RST,
                          rlf_pkg::STANDBY_FIRST_RST, rlf_pkg::STANDBY_SECOND_RST};
    bit [23:0] want_col  [LED_COUNT] = '{default: '0};
    bit        want_lit  [LED_COUNT] = '{default: 1'b0};
    bit [23:0] shown_col [LED_COUNT] = '{default: '0};
    bit        shown_lit [LED_COUNT] = '{default: 1'b0};
    t_led_res  due_leds[$];          // LED items still owed by the block

    string REG_NAMES [4] = '{"fade_step", "on_colour", "standby_first", "standby_second"};

    int fails = 0;
    int ticks_sent = 0;
    int leds_seen = 0;
    int reg_writes = 0;
    bit calm = 1'b0;                 // no idling on either side while set
    int hold_cycles = 0;             // receiver hold-off still to run

    // ------------------------------------------------------------------
    // Pattern predictor
    // ------------------------------------------------------------------

    function automatic void want_on();
        foreach (want_col[i]) begin
            want_col[i] = cfg.on_colour;
            want_lit[i] = 1'b1;
        end
    endfunction

    // LED zero and one lit in their own colours, the rest dark
    function automatic void want_standby();
        foreach (want_col[i]) begin
            want_col[i] = '0;
            want_lit[i] = 1'b0;
        end
        want_col[0] = cfg.standby_first;
        want_lit[0] = 1'b1;
        want_col[1] = cfg.standby_second;
        want_lit[1] = 1'b1;
    endfunction

    // Q1.8 scale, truncated, saturating at full scale
    function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [8:0] k);
        logic [16:0] p;
        p = c * k;
        return (p[16:8] > 9'd255) ? 8'hFF : p[15:8];
    endfunction

    // one fade step toward the target, or toward zero for an LED not wanted
    function automatic logic [7:0] step_chan(input logic [7:0] cur, tgt, input bit wanted);
        logic [7:0] fs, delta;
        fs = cfg.fade_step;
        if (!wanted)
            return (cur < fs) ? 8'd0 : cur - fs;
        delta = (tgt > cur) ? tgt - cur : cur - tgt;
        if (delta < fs)
            return tgt;
        return (tgt > cur) ? cur + fs : cur - fs;
    endfunction

    // Event first, then command, then fade if anything differs; owes one item per LED.
    function automatic void apply_tick(input t_tick t);
        logic [7:0] r, g, b;
        bit   moving;
        t_led_res res;
        case (t.switch_event)
            rlf_pkg::EV_ON:      want_on();
            rlf_pkg::EV_STANDBY: want_standby();
            default:    ;
        endcase
        case (t.mode)
            rlf_pkg::MODE_ON:      want_on();
            rlf_pkg::MODE_STANDBY: want_standby();
            rlf_pkg::MODE_SCALE:
                foreach (want_col[i])
                    want_col[i] = {scale_chan(want_col[i][23:16], t.brightness),
                                   scale_chan(want_col[i][15:8], t.brightness),
                                   scale_chan(want_col[i][7:0], t.brightness)};
            rlf_pkg::MODE_COLOUR:
                foreach (want_col[i])
                    want_col[i] = {t.red, t.green, t.blue};
            default:      ;
        endcase
        moving = 1'b0;
        foreach (want_col[i])
            if (shown_col[i] != want_col[i] || shown_lit[i] != want_lit[i])
                moving = 1'b1;
        if (moving) begin
            foreach (shown_col[i]) begin
                r = step_chan(shown_col[i][23:16], want_col[i][23:16], want_lit[i]);
                g = step_chan(shown_col[i][15:8], want_col[i][15:8], want_lit[i]);
                b = step_chan(shown_col[i][7:0], want_col[i][7:0], want_lit[i]);
                shown_col[i] = {r, g, b};
                shown_lit[i] = !(r < cfg.fade_step && g < cfg.fade_step && b < cfg.fade_step);
            end
        end
        foreach (shown_col[i]) begin
            res.led_index = 6'(i);
            res.red       = shown_col[i][23:16];
            res.green     = shown_col[i][15:8];
            res.blue      = shown_col[i][7:0];
            res.lit       = shown_lit[i];
            res.last_led  = (i == LED_COUNT - 1);
            due_leds.push_back(res);
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] due, got);
        if (got !== due) begin
            $error("%s: expected %0d, got %0d", name, due, got);
            fails++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------

    // setup cycle then access cycle; data sampled on the access edge
    task automatic reg_access(input bit write, input logic [1:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_reg(input logic [1:0] idx, input logic [23:0] value);
        logic [31:0] unused;
        reg_access(1'b1, idx, {8'd0, value}, unused);
        reg_writes++;
        case (idx)
            rlf_pkg::REG_FADE_STEP:     cfg.fade_step      = value[7:0];
            rlf_pkg::REG_ON_COLOUR:     cfg.on_colour      = value;
            rlf_pkg::REG_STANDBY_FIRST: cfg.standby_first  = value;
            default:                    cfg.standby_second = value;
        endcase
    endtask

    task automatic set_all_regs(input logic [7:0] fs, input logic [23:0] on_c, sb1, sb2);
        set_reg(rlf_pkg::REG_FADE_STEP, {16'd0, fs});
        set_reg(rlf_pkg::REG_ON_COLOUR, on_c);
        set_reg(rlf_pkg::REG_STANDBY_FIRST, sb1);
        set_reg(rlf_pkg::REG_STANDBY_SECOND, sb2);
    endtask

    task automatic check_regs();
        logic [31:0] seen, due;
        for (int n = 0; n < 4; n++) begin
            reg_access(1'b0, 2'(n), 32'd0, seen);
            case (2'(n))
                rlf_pkg::REG_FADE_STEP:     due = {24'd0, cfg.fade_step};
                rlf_pkg::REG_ON_COLOUR:     due = {8'd0, cfg.on_colour};
                rlf_pkg::REG_STANDBY_FIRST: due = {8'd0, cfg.standby_first};
                default:                    due = {8'd0, cfg.standby_second};
            endcase
            check_field(REG_NAMES[n], due, seen);
        end
    endtask

    // ------------------------------------------------------------------
    // Tick items
    // ------------------------------------------------------------------

    function automatic t_tick make_tick(input logic [1:0] ev, input logic [2:0] m,
                                        input logic [8:0] k, input logic [7:0] r, g, b);
        t_tick t;
        t.switch_event = ev;
        t.mode         = m;
        t.brightness   = k;
        t.red          = r;
        t.green        = g;
        t.blue         = b;
        return t;
    endfunction

    // Mostly quiet ticks so fades can run to the end, with commands sprinkled in
    // and some unknown codes as noise.
    function automatic t_tick random_tick();
        t_tick t;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 12)      t.switch_event = rlf_pkg::EV_ON;
        else if (pick < 24) t.switch_event = rlf_pkg::EV_STANDBY;
        else                t.switch_event = 2'($urandom_range(EV_MAX, EV_NONE));
        pick = $urandom_range(99);
        if (pick < 55)      t.mode = MODE_NONE;
        else if (pick < 62) t.mode = 3'($urandom_range(MODE_MAX, rlf_pkg::MODE_COLOUR + 1));
        else                t.mode = 3'($urandom_range(rlf_pkg::MODE_COLOUR, rlf_pkg::MODE_ON));
        pick = $urandom_range(99);
        if (pick < 50)      t.brightness = 9'($urandom_range(256, 0));
        else if (pick < 80) t.brightness = 9'($urandom_range(256, 224));
        else                t.brightness = 9'($urandom_range(511, 257));
        if ($urandom_range(9) == 0) begin
            t.red   = $urandom_range(1) ? 8'hFF : 8'h00;
            t.green = $urandom_range(1) ? 8'hFF : 8'h00;
            t.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
        end else begin
            t.red   = 8'($urandom_range(255));
            t.green = 8'($urandom_range(255));
            t.blue  = 8'($urandom_range(255));
        end
        return t;
    endfunction

    // Offer one tick after a random gap; returns at the edge it is taken.
    task automatic send_tick(input t_tick t);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < 24)
                gap++;
            // now and then a longer pause
            if ($urandom_range(99) < 4)
                gap += $urandom_range(40, 1);
        end
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        switch_event <= t.switch_event;
        mode         <= t.mode;
        brightness   <= t.brightness;
        red_in       <= t.red;
        green_in     <= t.green;
        blue_in      <= t.blue;
        do @(posedge clk); while (!in_ready);
        ticks_sent++;
        apply_tick(t);
    endtask

    // Stop offering and wait until every owed LED item is back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_leds.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker, watchdog
    // ------------------------------------------------------------------

    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_ready <= 1'b0;
            hold_cycles--;
        end else begin
            out_ready <= calm || ($urandom_range(99) >= 24);
        end
    end

    always @(posedge clk) begin : check_leds
        t_led_res due;
        if (rst_n && out_valid && out_ready) begin
            leds_seen++;
            if (due_leds.size() == 0) begin
                $error("LED item for led %0d with none outstanding", led_index);
                fails++;
            end else begin
                due = due_leds.pop_front();
                check_field("led_index", due.led_index, led_index);
                check_field("red_out", due.red, red_out);
                check_field("green_out", due.green, green_out);
                check_field("blue_out", due.blue, blue_out);
                check_field("lit", due.lit, lit);
                check_field("last_led", due.last_led, last_led);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no handshake for %0d cycles, %0d LED items outstanding",
               QUIET_MAX, due_leds.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_register_defaults();
        check_regs();
    endtask

    // Every event and command at the reset settings, incl. unknown codes,
    // brightness at zero, unity and beyond, and event plus command together.
    task automatic test_directed_ticks();
        send_tick(make_tick(EV_NONE, MODE_NONE, 9'd0, 8'd0, 8'd0, 8'd0));  // nothing to do
        send_tick(make_tick(rlf_pkg::EV_ON, MODE_NONE, 9'd0, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(EV_NONE, MODE_NONE, 9'd0, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(EV_NONE, rlf_pkg::MODE_SCALE, 9'd256, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(EV_NONE, rlf_pkg::MODE_SCALE, 9'd128, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(EV_NONE, rlf_pkg::MODE_SCALE, 9'd0, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(EV_NONE, rlf_pkg::MODE_COLOUR, 9'd0, 8'hFF, 8'hFF, 8'hFF));
        send_tick(make_tick(EV_NONE, rlf_pkg::MODE_SCALE, 9'd511, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(EV_NONE, rlf_pkg::MODE_SCALE, 9'd257, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(EV_NONE, rlf_pkg::MODE_COLOUR, 9'd0, 8'h00, 8'h00, 8'h00));
        send_tick(make_tick(rlf_pkg::EV_STANDBY, MODE_NONE, 9'd0, 8'd0, 8'd0, 8'd0));
        // colour while in standby: dark LEDs must stay dark
        send_tick(make_tick(EV_NONE, rlf_pkg::MODE_COLOUR, 9'd0, 8'hFF, 8'h00, 8'h80));
        send_tick(make_tick(EV_MAX, 3'd5, 9'd300, 8'h12, 8'h34, 8'h56));
        send_tick(make_tick(EV_NONE, 3'd6, 9'd511, 8'hAA, 8'h55, 8'hAA));
        send_tick(make_tick(EV_NONE, MODE_MAX, 9'd256, 8'h55, 8'hAA, 8'h55));
        // command overrides the event in the same tick
        send_tick(make_tick(rlf_pkg::EV_ON, rlf_pkg::MODE_STANDBY, 9'd0, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(rlf_pkg::EV_STANDBY, rlf_pkg::MODE_ON, 9'd0, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(EV_NONE, rlf_pkg::MODE_ON, 9'd0, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(EV_NONE, rlf_pkg::MODE_STANDBY, 9'd0, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(rlf_pkg::EV_ON, rlf_pkg::MODE_COLOUR, 9'd0, 8'hFF, 8'h00, 8'hFF));
        drain();
    endtask

    // Register extremes: a full-scale step that converges at once so patterns
    // go equal, a zero step that freezes every colour, and a unit step.
    task automatic test_register_extremes();
        set_all_regs(8'd255, 24'hFFFFFF, 24'hFFFFFF, 24'h000000);
        check_regs();
        send_tick(make_tick(rlf_pkg::EV_ON, MODE_NONE, 9'd0, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(EV_NONE, MODE_NONE, 9'd0, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(EV_NONE, MODE_NONE, 9'd0, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(rlf_pkg::EV_STANDBY, MODE_NONE, 9'd0, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(EV_NONE, rlf_pkg::MODE_SCALE, 9'd511, 8'd0, 8'd0, 8'd0));
        drain();
        set_reg(rlf_pkg::REG_FADE_STEP, 24'd0);
        send_tick(make_tick(EV_NONE, rlf_pkg::MODE_COLOUR, 9'd0, 8'h80, 8'h40, 8'h20));
        send_tick(make_tick(rlf_pkg::EV_ON, MODE_NONE, 9'd0, 8'd0, 8'd0, 8'd0));
        drain();
        set_all_regs(8'd1, 24'h000000, 24'h010101, 24'hFFFFFF);
        check_regs();
        send_tick(make_tick(rlf_pkg::EV_ON, MODE_NONE, 9'd0, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(rlf_pkg::EV_STANDBY, MODE_NONE, 9'd0, 8'd0, 8'd0, 8'd0));
        send_tick(make_tick(EV_NONE, MODE_NONE, 9'd0, 8'd0, 8'd0, 8'd0));
        drain();
    endtask

    // Receiver holds off while ticks keep coming, so the block must stall its input.
    task automatic test_output_stall();
        @(posedge clk);
        hold_cycles = STALL_LEN;
        repeat (6) send_tick(random_tick());
        drain();
    endtask

    // Random ticks over several settings; phase three runs with no idling at all.
    task automatic test_random_ticks();
        logic [7:0] fs;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       fs = rlf_pkg::FADE_STEP_RST;
                1:       fs = 8'd1;
                2:       fs = 8'd255;
                3:       fs = 8'($urandom_range(32, 2));
                default: fs = 8'($urandom_range(255, 1));
            endcase
            set_all_regs(fs, 24'($urandom_range(24'hFFFFFF)),
                         24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)));
            @(posedge clk);
            calm = (phase == 3);
            repeat (PHASE_TICKS) send_tick(random_tick());
            drain();
        end
        @(posedge clk);
        calm = 1'b0;
        check_regs();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_register_defaults();
        test_directed_ticks();
        test_register_extremes();
        test_output_stall();
        test_random_ticks();

        // a frame's worth of quiet to catch any stray LED item
        repeat (2 * LED_COUNT + 1) @(posedge clk);
        $display("Covered %0d ticks and %0d LED items over %0d register writes,",
                 ticks_sent, leds_seen, reg_writes);
        $display("fade steps from 0 to 255 and a %0d-cycle output hold-off.", STALL_LEN);
        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
